// ===== src/cbt_pkg.sv =====
// ----------------------------------------------------------------------------
// cbt_pkg - shared types and constants for the can bit timing calculator
// Field widths, status and register codes, controller/datapath structs and
// the time segment table indexed by quanta count.
// ----------------------------------------------------------------------------
package cbt_pkg;

	localparam int RATE_W       = 20;
	localparam int CLK_W        = 28;
	localparam int TQ_W         = 5;
	localparam int NUM_W        = 29;
	localparam int PROD_W       = 34;
	localparam int CFG_W        = 28;
	localparam int CFG_IDX_W    = 2;
	localparam int LEAST_QUANTA = 7;
	localparam int DIV_CNT_W    = $clog2(NUM_W);

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_RANGE = 2'd1;
	localparam logic [1:0] STAT_PRESC = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_HZ = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RATE_MIN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RATE_MAX = 2'd2;

	typedef struct packed {
		logic load;
		logic mul_rate;
		logic mul_presc;
		logic div_start;
		logic div_second;
		logic cap_p;
		logic cap_got;
		logic cmp_upd;
		logic tq_dec;
		logic store;
	} cbt_cmd_t;

	typedef struct packed {
		logic range_bad;
		logic div_done;
		logic p_zero;
		logic tq_last;
		logic exact;
	} cbt_stat_t;

	typedef struct packed {
		logic [4:0] tseg1;
		logic [3:0] tseg2;
		logic [1:0] sjw;
	} seg_row_t;

	function automatic seg_row_t seg_lookup(input logic [TQ_W-1:0] tq);
		seg_row_t row;
		case (tq)
			5'd7:    row = '{5'd4,  4'd2, 2'd1};
			5'd8:    row = '{5'd5,  4'd2, 2'd1};
			5'd9:    row = '{5'd6,  4'd2, 2'd2};
			5'd10:   row = '{5'd6,  4'd3, 2'd2};
			5'd11:   row = '{5'd7,  4'd3, 2'd2};
			5'd12:   row = '{5'd8,  4'd3, 2'd2};
			5'd13:   row = '{5'd8,  4'd4, 2'd2};
			5'd14:   row = '{5'd9,  4'd4, 2'd2};
			5'd15:   row = '{5'd10, 4'd4, 2'd2};
			5'd16:   row = '{5'd10, 4'd5, 2'd2};
			5'd17:   row = '{5'd11, 4'd5, 2'd2};
			5'd18:   row = '{5'd12, 4'd5, 2'd2};
			5'd19:   row = '{5'd12, 4'd6, 2'd2};
			5'd20:   row = '{5'd13, 4'd6, 2'd2};
			5'd21:   row = '{5'd14, 4'd6, 2'd2};
			5'd22:   row = '{5'd14, 4'd7, 2'd2};
			5'd23:   row = '{5'd15, 4'd7, 2'd2};
			5'd24:   row = '{5'd15, 4'd8, 2'd2};
			5'd25:   row = '{5'd16, 4'd8, 2'd2};
			default: row = '{5'd0,  4'd0, 2'd0};
		endcase
		return row;
	endfunction

endpackage

// ===== src/cbt_div.sv =====
// ----------------------------------------------------------------------------
// cbt_div - iterative restoring divider
// One quotient bit per cycle; done pulses as the last bit enters the quotient.
// ----------------------------------------------------------------------------
module cbt_div import cbt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [NUM_W-1:0]  dividend,
	input  logic [PROD_W-1:0] divisor,
	output logic              done,
	output logic [NUM_W-1:0]  quotient
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [PROD_W-1:0]    rem_q;
	logic [PROD_W-1:0]    den_q;
	logic [NUM_W-1:0]     quo_q;
	logic [PROD_W:0]      trial;
	logic [PROD_W:0]      diff;
	logic                 take;

	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign take  = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(NUM_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// dividend bits shift out the top while quotient bits shift in below
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			den_q <= divisor;
		end else if (busy_q) begin
			rem_q <= take ? diff[PROD_W-1:0] : trial[PROD_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], take};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider restarted while busy");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("divider done held for more than one cycle");

endmodule

// ===== src/cbt_dp.sv =====
// ----------------------------------------------------------------------------
// cbt_dp - bit timing datapath
// Configuration registers, candidate multiplier, shared divider, best-fit
// tracking and the result register with byte packing.
// ----------------------------------------------------------------------------
module cbt_dp import cbt_pkg::*; #(
	parameter int MAX_PRESCALER = 64,
	parameter int MAX_QUANTA    = 25
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic [RATE_W-1:0]    req_rate,
	input  cbt_cmd_t             cmd,
	output cbt_stat_t            stat,
	output logic [1:0]           status,
	output logic [7:0]           timing_byte0,
	output logic [6:0]           timing_byte1,
	output logic [6:0]           prescaler,
	output logic [4:0]           quanta_count
);

	logic [CLK_W-1:0]  clock_hz_q;
	logic [RATE_W-1:0] rate_min_q;
	logic [RATE_W-1:0] rate_max_q;
	logic [RATE_W-1:0] rate_q;
	logic [TQ_W-1:0]   tq_q;
	logic [PROD_W-1:0] prod_q;
	logic [NUM_W-1:0]  p_q;
	logic [CLK_W-1:0]  got_q;
	logic              have_best_q;
	logic [TQ_W-1:0]   best_tq_q;
	logic [NUM_W-1:0]  best_p_q;
	logic [CLK_W-1:0]  best_dev_q;
	logic [1:0]        status_q;
	logic [7:0]        byte0_q;
	logic [6:0]        byte1_q;
	logic [6:0]        presc_q;
	logic [4:0]        tq_out_q;

	logic              range_bad;
	logic [CLK_W-1:0]  rate_x;
	logic [CLK_W-1:0]  dev;
	logic              better;
	logic [NUM_W-1:0]  div_num;
	logic              div_done;
	logic [NUM_W-1:0]  div_quo;
	logic [NUM_W-1:0]  p_m1;
	logic              presc_bad;
	seg_row_t          row;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_hz_q <= CLK_W'(33000000);
			rate_min_q <= RATE_W'(10000);
			rate_max_q <= RATE_W'(1000000);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CLOCK_HZ: clock_hz_q <= cfg_data;
				CFG_RATE_MIN: rate_min_q <= cfg_data[RATE_W-1:0];
				CFG_RATE_MAX: rate_max_q <= cfg_data[RATE_W-1:0];
				default: ;
			endcase
		end
	end

	assign range_bad = (rate_q == '0) || (rate_q < rate_min_q) || (rate_q > rate_max_q);

	// got never exceeds the clock, so it fits the clock width
	assign rate_x = CLK_W'(rate_q);
	assign dev    = (rate_x >= got_q) ? rate_x - got_q : got_q - rate_x;
	assign better = !have_best_q || (dev < best_dev_q);

	// rounded prescaler: (clock + fq/2) / fq, then clock / (tq * p)
	assign div_num = cmd.div_second ? NUM_W'(clock_hz_q)
		: NUM_W'(clock_hz_q) + NUM_W'(prod_q >> 1);

	cbt_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_num),
		.divisor  (prod_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_best_q <= 1'b0;
		end else if (cmd.load) begin
			have_best_q <= 1'b0;
		end else if (cmd.cmp_upd && better) begin
			have_best_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rate_q <= req_rate;
			tq_q   <= TQ_W'(MAX_QUANTA);
		end else if (cmd.tq_dec) begin
			tq_q <= tq_q - 1'b1;
		end
		if (cmd.mul_rate) begin
			prod_q <= PROD_W'(tq_q) * PROD_W'(rate_q);
		end else if (cmd.mul_presc) begin
			prod_q <= PROD_W'(tq_q) * PROD_W'(p_q);
		end
		if (cmd.cap_p) begin
			p_q <= div_quo;
		end
		if (cmd.cap_got) begin
			got_q <= div_quo[CLK_W-1:0];
		end
		if (cmd.cmp_upd && better) begin
			best_tq_q  <= tq_q;
			best_p_q   <= p_q;
			best_dev_q <= dev;
		end
	end

	assign row       = seg_lookup(best_tq_q);
	assign p_m1      = best_p_q - 1'b1;
	assign presc_bad = !have_best_q || (best_p_q > NUM_W'(MAX_PRESCALER));

	always_ff @(posedge clk) begin
		if (cmd.store) begin
			if (range_bad) begin
				status_q <= STAT_RANGE;
				byte0_q  <= '0;
				byte1_q  <= '0;
				presc_q  <= '0;
				tq_out_q <= '0;
			end else if (presc_bad) begin
				status_q <= STAT_PRESC;
				byte0_q  <= '0;
				byte1_q  <= '0;
				presc_q  <= '0;
				tq_out_q <= '0;
			end else begin
				status_q <= STAT_OK;
				byte0_q  <= {row.sjw - 2'd1, p_m1[5:0]};
				byte1_q  <= {3'(row.tseg2 - 4'd1), 4'(row.tseg1 - 5'd1)};
				presc_q  <= best_p_q[6:0];
				tq_out_q <= best_tq_q;
			end
		end
	end

	assign stat.range_bad = range_bad;
	assign stat.div_done  = div_done;
	assign stat.p_zero    = (p_q == '0);
	assign stat.tq_last   = (tq_q == TQ_W'(LEAST_QUANTA));
	assign stat.exact     = (dev == '0);

	assign status       = status_q;
	assign timing_byte0 = byte0_q;
	assign timing_byte1 = byte1_q;
	assign prescaler    = presc_q;
	assign quanta_count = tq_out_q;

	a_got_nonzero_presc: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cap_got |-> (p_q != '0))
		else $error("bit rate computed for a zero prescaler");

	a_best_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.store && have_best_q) |->
		(best_tq_q >= TQ_W'(LEAST_QUANTA)) && (best_tq_q <= TQ_W'(MAX_QUANTA)))
		else $error("chosen quanta count outside the segment table");

endmodule

// ===== src/cbt_ctrl.sv =====
// ----------------------------------------------------------------------------
// cbt_ctrl - search sequencer
// Walks the quanta counts from the top down, steering the multiplier and the
// shared divider, and owns the transaction handshakes.
// ----------------------------------------------------------------------------
module cbt_ctrl import cbt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  cbt_stat_t stat,
	output cbt_cmd_t  cmd
);

	typedef enum logic [10:0] {
		S_IDLE  = 11'b000_0000_0001,
		S_CHECK = 11'b000_0000_0010,
		S_MUL1  = 11'b000_0000_0100,
		S_GO1   = 11'b000_0000_1000,
		S_DIV1  = 11'b000_0001_0000,
		S_MUL2  = 11'b000_0010_0000,
		S_GO2   = 11'b000_0100_0000,
		S_DIV2  = 11'b000_1000_0000,
		S_CMP   = 11'b001_0000_0000,
		S_NEXT  = 11'b010_0000_0000,
		S_DONE  = 11'b100_0000_0000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		state_d  = state_q;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_CHECK;
				end
			end
			S_CHECK: begin
				state_d = stat.range_bad ? S_DONE : S_MUL1;
			end
			S_MUL1: begin
				cmd.mul_rate = 1'b1;
				state_d      = S_GO1;
			end
			S_GO1: begin
				cmd.div_start = 1'b1;
				state_d       = S_DIV1;
			end
			S_DIV1: begin
				if (stat.div_done) begin
					cmd.cap_p = 1'b1;
					state_d   = S_MUL2;
				end
			end
			S_MUL2: begin
				// a prescaler that rounds to zero skips this count
				if (stat.p_zero) begin
					state_d = S_NEXT;
				end else begin
					cmd.mul_presc = 1'b1;
					state_d       = S_GO2;
				end
			end
			S_GO2: begin
				cmd.div_start  = 1'b1;
				cmd.div_second = 1'b1;
				state_d        = S_DIV2;
			end
			S_DIV2: begin
				if (stat.div_done) begin
					cmd.cap_got = 1'b1;
					state_d     = S_CMP;
				end
			end
			S_CMP: begin
				cmd.cmp_upd = 1'b1;
				state_d     = stat.exact ? S_DONE : S_NEXT;
			end
			S_NEXT: begin
				if (stat.tq_last) begin
					state_d = S_DONE;
				end else begin
					cmd.tq_dec = 1'b1;
					state_d    = S_MUL1;
				end
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.store = 1'b1;
					state_d   = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.store) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== src/can_bit_timing_calculator.sv =====
// ----------------------------------------------------------------------------
// can_bit_timing_calculator - prescaler and segment search for a bus bit rate
// Checks the requested rate against the configured limits, searches quanta
// counts for the best rounded prescaler and packs the two timing bytes.
// ----------------------------------------------------------------------------
// usage:
//   config: cfg_we/cfg_index/cfg_data write clock_hz, rate_min, rate_max,
//   one register per cycle, only while no transaction is in flight
//   input: req_rate taken on in_valid & in_ready; ready is high only while
//   the sequencer is idle, so one request is worked on at a time
//   output: status, both timing bytes, prescaler and quanta count, held in a
//   register under out_valid until out_ready
//   search: an out-of-range rate is answered without a search; otherwise each
//   quanta count takes a rounding division and, unless the prescaler rounds to
//   zero, a second division on the shared divider, up to 19 counts; an exact
//   match ends the search early
//   a new request may be taken while the previous result still waits
//   stall: a finished result waits until the output register is free
//   reset: registers return to 33 MHz, 10 kbit/s and 1 Mbit/s, no output
// ----------------------------------------------------------------------------
module can_bit_timing_calculator import cbt_pkg::*; #(
	parameter int MAX_PRESCALER = 64,
	parameter int MAX_QUANTA    = 25
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [RATE_W-1:0]    req_rate,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [1:0]           status,
	output logic [7:0]           timing_byte0,
	output logic [6:0]           timing_byte1,
	output logic [6:0]           prescaler,
	output logic [4:0]           quanta_count
);

	cbt_cmd_t  cmd;
	cbt_stat_t stat;

	cbt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	cbt_dp #(
		.MAX_PRESCALER (MAX_PRESCALER),
		.MAX_QUANTA    (MAX_QUANTA)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.req_rate     (req_rate),
		.cmd          (cmd),
		.stat         (stat),
		.status       (status),
		.timing_byte0 (timing_byte0),
		.timing_byte1 (timing_byte1),
		.prescaler    (prescaler),
		.quanta_count (quanta_count)
	);

endmodule

// ===== sim/can_bit_timing_calculator_tb.sv =====
// ----------------------------------------------------------------------------
// can_bit_timing_calculator_tb - self-checking bench for the bit timing search
// Writes several clock and rate-limit settings, sends directed and random bit
// rate requests and checks every result against a local prescaler search.
// Both handshakes idle in random bursts; the receiver holds off once for long.
// ----------------------------------------------------------------------------
module can_bit_timing_calculator_tb import cbt_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TOP_QUANTA   = 25;
	localparam int PRESC_LIMIT  = 64;
	localparam int QUIET_LIMIT  = 20000;
	localparam int LONG_HOLD    = 3000;
	localparam int TAIL_CYCLES  = 1400;
	localparam int RAND_PHASES  = 8;
	localparam int RAND_PER_PH  = 50;
	localparam int CALM_ITEMS   = 60;

	// segment table, row 0 is seven quanta
	localparam int TSEG1_TAB [0:18] = '{4, 5, 6, 6, 7, 8, 8, 9, 10, 10, 11, 12, 12, 13, 14,
		14, 15, 15, 16};
	localparam int TSEG2_TAB [0:18] = '{2, 2, 2, 3, 3, 3, 4, 4, 4, 5, 5, 5, 6, 6, 6, 7, 7,
		8, 8};
	localparam int SJW_TAB [0:18] = '{1, 1, 2, 2, 2, 2, 2, 2, 2, 2, 2, 2, 2, 2, 2, 2, 2, 2, 2};

	typedef struct packed {
		logic [RATE_W-1:0] rate;
		logic [1:0]        status;
		logic [7:0]        byte0;
		logic [6:0]        byte1;
		logic [6:0]        presc;
		logic [TQ_W-1:0]   tq;
	} timing_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_CLOCK_HZ;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [RATE_W-1:0]    req_rate = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [1:0]           status;
	logic [7:0]           timing_byte0;
	logic [6:0]           timing_byte1;
	logic [6:0]           prescaler;
	logic [4:0]           quanta_count;

	// current register contents as the block should see them
	logic [CLK_W-1:0]  hz_cfg = 28'd33000000;
	logic [RATE_W-1:0] lo_cfg = 20'd10000;
	logic [RATE_W-1:0] hi_cfg = 20'd1000000;

	logic [RATE_W-1:0] rate_queue [$];
	timing_t           timing_due [$];

	int  fail_cnt = 0;
	int  sent_cnt = 0;
	int  ok_cnt = 0;
	int  range_cnt = 0;
	int  presc_cnt = 0;
	int  cfg_sets = 0;
	int  odds = 4;
	int  src_gap = 0;
	int  sink_gap = 0;
	int  hold_left = 0;
	bit  hold_go = 1'b0;
	bit  hold_done = 1'b0;
	int  quiet_cycles = 0;

	can_bit_timing_calculator u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.req_rate     (req_rate),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.timing_byte0 (timing_byte0),
		.timing_byte1 (timing_byte1),
		.prescaler    (prescaler),
		.quanta_count (quanta_count)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// rounded prescaler search over quanta counts, first exact hit wins
	function automatic timing_t calc_bit_timing(input logic [RATE_W-1:0] rate);
		timing_t         r;
		longint unsigned hz, want, fq, p, got, dev, best_dev, best_p;
		int              tq, best_tq, row;
		bit              hit;
		r = '0;
		r.rate = rate;
		r.status = STAT_OK;
		if (rate == 0 || rate < lo_cfg || rate > hi_cfg) begin
			r.status = STAT_RANGE;
			return r;
		end
		hz = hz_cfg;
		want = rate;
		best_dev = 64'hFFFF_FFFF;
		best_p = 0;
		best_tq = 0;
		hit = 1'b0;
		for (tq = TOP_QUANTA; tq >= LEAST_QUANTA && !hit; tq--) begin
			fq = 64'(tq) * want;
			p = (hz + fq / 2) / fq;
			if (p != 0) begin
				got = hz / (64'(tq) * p);
				dev = (want >= got) ? want - got : got - want;
				if (dev == 0) begin
					hit = 1'b1;
					best_tq = tq;
					best_p = p;
				end else if (dev < best_dev) begin
					best_dev = dev;
					best_tq = tq;
					best_p = p;
				end
			end
		end
		if (best_tq == 0 || best_p > PRESC_LIMIT) begin
			r.status = STAT_PRESC;
			return r;
		end
		row = best_tq - LEAST_QUANTA;
		r.byte0 = {2'(SJW_TAB[row] - 1), 6'(best_p - 1)};
		r.byte1 = {3'(TSEG2_TAB[row] - 1), 4'(TSEG1_TAB[row] - 1)};
		r.presc = 7'(best_p);
		r.tq = 5'(best_tq);
		return r;
	endfunction

	task automatic check_field(input string name, input int unsigned want,
		input int unsigned got, input logic [RATE_W-1:0] rate);
		if (want != got) begin
			$display("%0t: %s mismatch for bit rate %0d: expected %0d, actual %0d",
				$time, name, rate, want, got);
			fail_cnt++;
		end
	endtask

	task automatic check_result();
		timing_t want;
		if (timing_due.size() == 0) begin
			$display("%0t: unexpected result, expected none, actual status %0d",
				$time, status);
			fail_cnt++;
			return;
		end
		want = timing_due.pop_front();
		check_field("status", want.status, status, want.rate);
		check_field("timing_byte0", want.byte0, timing_byte0, want.rate);
		check_field("timing_byte1", want.byte1, timing_byte1, want.rate);
		check_field("prescaler", want.presc, prescaler, want.rate);
		check_field("quanta_count", want.tq, quanta_count, want.rate);
		case (want.status)
			STAT_OK:    ok_cnt++;
			STAT_RANGE: range_cnt++;
			default:    presc_cnt++;
		endcase
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			req_rate <= '0;
		end else begin
			if (in_valid && in_ready) begin
				timing_due.push_back(calc_bit_timing(req_rate));
				sent_cnt++;
			end
			if (!in_valid || in_ready) begin
				if (src_gap > 0) begin
					src_gap--;
					in_valid <= 1'b0;
				end else if (rate_queue.size() == 0) begin
					in_valid <= 1'b0;
				end else if (odds != 0 && $urandom_range(0, odds) == 0) begin
					src_gap = $urandom_range(1, 17) - 1;
					in_valid <= 1'b0;
				end else begin
					in_valid <= 1'b1;
					req_rate <= rate_queue.pop_front();
				end
			end
		end
	end

	// result monitor and receiver stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready)
				check_result();
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (hold_go && !hold_done) begin
				hold_done = 1'b1;
				hold_left = LONG_HOLD - 1;
				out_ready <= 1'b0;
			end else if (sink_gap > 0) begin
				sink_gap--;
				out_ready <= 1'b0;
			end else if (odds != 0 && $urandom_range(0, odds) == 0) begin
				sink_gap = $urandom_range(1, 17) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles = 0;
		else if (arst_n)
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic set_config(input logic [CLK_W-1:0] hz, input logic [RATE_W-1:0] lo,
		input logic [RATE_W-1:0] hi);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_CLOCK_HZ;
		cfg_data <= CFG_W'(hz);
		@(posedge clk);
		cfg_index <= CFG_RATE_MIN;
		cfg_data <= CFG_W'(lo);
		@(posedge clk);
		cfg_index <= CFG_RATE_MAX;
		cfg_data <= CFG_W'(hi);
		@(posedge clk);
		cfg_we <= 1'b0;
		hz_cfg = hz;
		lo_cfg = lo;
		hi_cfg = hi;
		cfg_sets++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		while (rate_queue.size() != 0 || in_valid || timing_due.size() != 0)
			@(negedge clk);
	endtask

	function automatic logic [RATE_W-1:0] std_rate();
		case ($urandom_range(0, 8))
			0:       return 20'd10000;
			1:       return 20'd20000;
			2:       return 20'd50000;
			3:       return 20'd100000;
			4:       return 20'd125000;
			5:       return 20'd250000;
			6:       return 20'd500000;
			7:       return 20'd800000;
			default: return 20'd1000000;
		endcase
	endfunction

	task automatic random_config();
		logic [CLK_W-1:0]  hz;
		logic [RATE_W-1:0] lo, hi;
		case ($urandom_range(0, 3))
			0:       hz = CLK_W'($urandom_range(1, 200) * 1000000);
			1:       hz = CLK_W'($urandom_range(1, 200000000));
			2:       hz = CLK_W'($urandom_range(1, 3000000));
			default: hz = $urandom_range(0, 1) ? 28'd33000000 : 28'd200000000;
		endcase
		case ($urandom_range(0, 5))
			0:       lo = '0;
			1:       lo = RATE_W'($urandom_range(0, 1000000));
			default: lo = RATE_W'($urandom_range(1, 20000));
		endcase
		if ($urandom_range(0, 5) == 0)
			hi = RATE_W'($urandom_range(0, 1000000));
		else
			hi = RATE_W'($urandom_range(500000, 1000000));
		set_config(hz, lo, hi);
	endtask

	task automatic queue_random(input int n);
		logic [RATE_W-1:0] r;
		repeat (n) begin
			case ($urandom_range(0, 9))
				0, 1:    r = std_rate();
				2:       r = RATE_W'($urandom_range(0, 1000000));
				default: r = (lo_cfg <= hi_cfg) ? RATE_W'($urandom_range(hi_cfg, lo_cfg))
					: RATE_W'($urandom_range(0, 1000000));
			endcase
			rate_queue.push_back(r);
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings, exact match at eleven quanta and the range edges
		rate_queue = '{20'd0, 20'd9999, 20'd10000, 20'd125000, 20'd250000, 20'd500000,
			20'd1000000, 20'd83333, 20'd20000};
		wait_drained();

		// fastest clock: a tiny rate needs a prescaler far above the limit
		set_config(28'd200000000, 20'd1, 20'd1000000);
		rate_queue = '{20'd1, 20'd1000, 20'd1000000, 20'd125000};
		wait_drained();

		// 1 Hz clock, zero lower limit: zero rate still refused, no count usable
		set_config(28'd1, 20'd0, 20'd1000000);
		rate_queue = '{20'd0, 20'd1, 20'd7};
		wait_drained();

		// some quanta counts round to a zero prescaler and are skipped
		set_config(28'd100, 20'd1, 20'd100);
		rate_queue = '{20'd10, 20'd4, 20'd100, 20'd101};
		wait_drained();

		// lower limit above upper limit
		set_config(28'd16000000, 20'd500000, 20'd400000);
		rate_queue = '{20'd450000, 20'd500000, 20'd400000};
		wait_drained();

		set_config(28'd200000000, 20'd1000000, 20'd1000000);
		rate_queue = '{20'd1000000, 20'd999999};
		wait_drained();

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			random_config();
			case ($urandom_range(0, 2))
				0:       odds = 0;
				1:       odds = 2;
				default: odds = 8;
			endcase
			// receiver stalls long enough for the block to back up its input
			if (ph == 1)
				hold_go = 1'b1;
			queue_random(RAND_PER_PH);
			wait_drained();
		end

		// last stretch runs at full rate on both sides
		odds = 0;
		set_config(28'd40000000, 20'd1, 20'd1000000);
		queue_random(CALM_ITEMS);
		wait_drained();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (timing_due.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, timing_due.size());
			fail_cnt += timing_due.size();
		end
		$display("%0d bit rate requests under %0d register settings: %0d ok,",
			sent_cnt, cfg_sets, ok_cnt);
		$display("%0d refused on range, %0d on prescaler, receiver stalled %0d cycles once",
			range_cnt, presc_cnt, LONG_HOLD);
		if (fail_cnt == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
